FILE: rtl/core/s256pow_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s256pow_pkg
// Shared types, constants and functions of the SHA-256 share checker.
// ----------------------------------------------------------------------------
package s256pow_pkg;

  localparam int unsigned NUM_ROUNDS = 64;
  localparam int unsigned SCAN_BYTES = 31;
  localparam logic [15:0] ALL_ZERO_SCORE = 16'd63488;

  typedef enum logic [2:0] {
    REG_BH0    = 3'd0,
    REG_BH1    = 3'd1,
    REG_BH2    = 3'd2,
    REG_BH3    = 3'd3,
    REG_PFX_LO = 3'd4,
    REG_PFX_HI = 3'd5,
    REG_DIFF   = 3'd6
  } cfg_reg_t;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a, b, c, d, e, f, g, h;
  } hstate_t;

  typedef struct packed {
    logic [47:0] ending;
    logic [15:0] count;
  } tag_t;

  localparam hstate_t H_INIT = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    begin
      case (i)
        6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
        6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
        6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
        6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
        6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
        6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
        6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
        6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
        6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
        6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
        6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
        6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
        6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
        6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
        6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
        6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
        6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
        6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
        6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
        6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
        6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
        6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
        6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

endpackage

FILE: rtl/core/s256pow_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s256pow_cell
// One SHA-256 round cell: updates the working state, advances the 16-word
// schedule window and carries the candidate tag to the next cell.
// ----------------------------------------------------------------------------
module s256pow_cell #(
  parameter logic [5:0] ROUND = 6'd0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    vld_i,
  input  s256pow_pkg::hstate_t    st_i,
  input  logic [511:0]            win_i,
  input  s256pow_pkg::tag_t       tag_i,
  output logic                    vld_o,
  output s256pow_pkg::hstate_t    st_o,
  output logic [511:0]            win_o,
  output s256pow_pkg::tag_t       tag_o
);
  import s256pow_pkg::*;

  logic    vld_r;
  hstate_t st_r, st_nxt;
  logic [511:0] win_r, win_nxt;
  tag_t    tag_r;
  word_t   w0, w1, w9, w14, s0, s1, wn, t1, t2, ep0, ep1, ch, mj;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // window word j sits at bits [511-32j -: 32]; word 0 is the current round
  always_comb begin
    w0  = win_i[511 -: 32];
    w1  = win_i[479 -: 32];
    w9  = win_i[223 -: 32];
    w14 = win_i[63 -: 32];
    s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    wn  = w0 + s0 + w9 + s1;
    win_nxt = {win_i[479:0], wn};
    ep1 = rotr(st_i.e, 6) ^ rotr(st_i.e, 11) ^ rotr(st_i.e, 25);
    ch  = (st_i.e & st_i.f) ^ (~st_i.e & st_i.g);
    ep0 = rotr(st_i.a, 2) ^ rotr(st_i.a, 13) ^ rotr(st_i.a, 22);
    mj  = (st_i.a & st_i.b) ^ (st_i.a & st_i.c) ^ (st_i.b & st_i.c);
    t1  = st_i.h + ep1 + ch + round_k(ROUND) + w0;
    t2  = ep0 + mj;
    st_nxt = '{t1 + t2, st_i.a, st_i.b, st_i.c, st_i.d + t1, st_i.e, st_i.f, st_i.g};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r  <= st_nxt;
      win_r <= win_nxt;
      tag_r <= tag_i;
    end
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;
  assign win_o = win_r;
  assign tag_o = tag_r;

endmodule

FILE: rtl/core/s256pow_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s256pow_score
// Final state add, leading-zero score and share compare; registered output.
// ----------------------------------------------------------------------------
module s256pow_score (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    vld_i,
  input  s256pow_pkg::hstate_t    st_i,
  input  s256pow_pkg::tag_t       tag_i,
  input  logic [15:0]             diff_i,
  output logic                    vld_o,
  output logic                    meets_o,
  output logic [15:0]             score_o,
  output s256pow_pkg::tag_t       tag_o
);
  import s256pow_pkg::*;

  logic         vld_r, vld2_r;
  logic [255:0] dig_r;
  tag_t         tag_r, tag2_r;
  logic [15:0]  score_r, score_nxt;
  logic         meets_r;
  logic [255:0] dig_nxt;
  logic [8*SCAN_BYTES-1:0] top;
  logic         found;
  logic [7:0]   lz;

  always_comb begin
    dig_nxt = {st_i.a + H_INIT.a, st_i.b + H_INIT.b, st_i.c + H_INIT.c, st_i.d + H_INIT.d,
               st_i.e + H_INIT.e, st_i.f + H_INIT.f, st_i.g + H_INIT.g, st_i.h + H_INIT.h};
  end

  always_comb begin
    top   = dig_r[255 -: 8*SCAN_BYTES];
    found = 1'b0;
    lz    = 8'd0;
    for (int i = 0; i < 8*SCAN_BYTES; i++) begin
      if (!found && top[8*SCAN_BYTES - 1 - i]) begin
        found = 1'b1;
        lz    = 8'(i);
      end
    end
    if (found) begin
      score_nxt = {lz, 8'(dig_r << (32'd1 + {24'd0, lz}) >> 248)};
    end else begin
      score_nxt = ALL_ZERO_SCORE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld_r  <= vld_i;
      vld2_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dig_r   <= dig_nxt;
      tag_r   <= tag_i;
      tag2_r  <= tag_r;
      score_r <= score_nxt;
      meets_r <= (score_nxt >= diff_i);
    end
  end

  assign vld_o   = vld2_r;
  assign meets_o = meets_r;
  assign score_o = score_r;
  assign tag_o   = tag2_r;

endmodule

FILE: rtl/core/sha256_pow_share_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pow_share_check
// Proof-of-work share checker: one padded SHA-256 block per candidate,
// leading-zero score, share compare.
//
//  channel | handshake          | payload
//  in_     | in_valid/in_stall  | nonce_ending, inner_count
//  out_    | out_valid/out_stall| meets_share, score, echoes
//  cfg_    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One candidate per cycle unless stalled; 64 round cells plus two scoring
// stages. The whole chain advances together and freezes while the output is
// stalled and full. Reset clears the valid bits and config registers to zero.
// ----------------------------------------------------------------------------
module sha256_pow_share_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] in_nonce_ending,
  input  logic [15:0] in_inner_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_meets_share,
  output logic [15:0] out_score,
  output logic [47:0] out_nonce_ending_echo,
  output logic [15:0] out_inner_count_echo,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import s256pow_pkg::*;

  logic [63:0] bh0_r, bh1_r, bh2_r, bh3_r, pl_r;
  logic [55:0] ph_r;
  logic [15:0] diff_r;
  logic        adv;
  logic [511:0] blk;
  logic [NUM_ROUNDS:0]  vld;
  hstate_t              st  [NUM_ROUNDS+1];
  logic [511:0]         win [NUM_ROUNDS+1];
  tag_t                 tag [NUM_ROUNDS+1];
  tag_t                 otag;

  function automatic logic [63:0] bswap64(input logic [63:0] v);
    logic [63:0] r;
    begin
      for (int i = 0; i < 8; i++) r[63 - 8*i -: 8] = v[8*i +: 8];
      return r;
    end
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bh0_r <= '0; bh1_r <= '0; bh2_r <= '0; bh3_r <= '0;
      pl_r  <= '0; ph_r  <= '0; diff_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BH0:    bh0_r  <= cfg_data;
        REG_BH1:    bh1_r  <= cfg_data;
        REG_BH2:    bh2_r  <= cfg_data;
        REG_BH3:    bh3_r  <= cfg_data;
        REG_PFX_LO: pl_r   <= cfg_data;
        REG_PFX_HI: ph_r   <= cfg_data[55:0];
        REG_DIFF:   diff_r <= cfg_data[15:0];
        default:    ;
      endcase
    end
  end

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // message bytes big-endian into the block, then pad and length 440
  logic [63:0] tail;
  logic [63:0] phs;
  always_comb begin
    phs  = bswap64({8'h00, ph_r});
    tail = bswap64({in_inner_count, in_nonce_ending});
    blk = {bswap64(bh0_r), bswap64(bh1_r), bswap64(bh2_r), bswap64(bh3_r),
           bswap64(pl_r), phs[63:8], tail,
           8'h80, 48'd0, 16'd440};
  end

  assign vld[0] = in_valid;
  assign st[0]  = H_INIT;
  assign win[0] = blk;
  assign tag[0] = '{in_nonce_ending, in_inner_count};

  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
    s256pow_cell #(.ROUND(6'(r))) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .vld_i(vld[r]), .st_i(st[r]), .win_i(win[r]), .tag_i(tag[r]),
      .vld_o(vld[r+1]), .st_o(st[r+1]), .win_o(win[r+1]), .tag_o(tag[r+1])
    );
  end

  s256pow_score u_score (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .vld_i(vld[NUM_ROUNDS]), .st_i(st[NUM_ROUNDS]), .tag_i(tag[NUM_ROUNDS]),
    .diff_i(diff_r), .vld_o(out_valid), .meets_o(out_meets_share),
    .score_o(out_score), .tag_o(otag)
  );

  assign out_nonce_ending_echo = otag.ending;
  assign out_inner_count_echo  = otag.count;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_score))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_score_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_score <= ALL_ZERO_SCORE)
    else $error("score out of range");
`endif

endmodule
